/* hdl/euq_pkg.sv */
// ----------------------------------------------------------------------------
// euq_pkg
// Shared widths, payload types, CORDIC angle table and fixed-point helpers
// for the Euler angle / quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package euq_pkg;

  localparam int XW       = 58;
  localparam int ZW       = 34;
  localparam int QW       = 34;
  localparam int SW       = 37;
  localparam int NW       = 61;
  localparam int SQ_CELLS = 31;
  localparam int TAB_LEN  = 40;

  localparam logic signed [XW-1:0] GAIN_INV = XW'(64'sd652032874);
  localparam logic signed [ZW-1:0] HALF_PI  = ZW'(64'sd1073741824);
  localparam logic signed [SW-1:0] ONE_Q30  = SW'(64'sd1073741824);

  localparam int ATAN_TAB [TAB_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic               kind;
    logic signed [31:0] roll_in;
    logic signed [31:0] pitch_in;
    logic signed [31:0] yaw_in;
    logic signed [31:0] qx_in;
    logic signed [31:0] qy_in;
    logic signed [31:0] qz_in;
    logic signed [31:0] qw_in;
  } in_t;

  typedef struct packed {
    logic               kind_out;
    logic signed [31:0] qx_out;
    logic signed [31:0] qy_out;
    logic signed [31:0] qz_out;
    logic signed [31:0] qw_out;
    logic signed [31:0] roll_out;
    logic signed [31:0] pitch_out;
    logic signed [31:0] yaw_out;
    logic               pitch_clamped;
  } out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] zero;
    logic       hi;
    logic       lo;
  } side_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [SW-1:0] yaw_y;
    logic signed [SW-1:0] yaw_x;
    logic signed [SW-1:0] roll_y;
    logic signed [SW-1:0] roll_x;
    logic signed [SW-1:0] sine;
    logic               hi;
    logic               lo;
  } pre_t;

  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    p = p + $signed((2*QW)'(64'd536870912));
    return QW'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [QW:0] v);
    if (v > $signed((QW+1)'(64'sd2147483647))) return 32'sh7fffffff;
    if (v < $signed(-(QW+1)'(64'sd2147483648))) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/euq_if.sv */
// ----------------------------------------------------------------------------
// euq_if
// Valid/ready channels carrying the converter's input and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface euq_in_if;
  logic          valid;
  logic          ready;
  euq_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface euq_out_if;
  logic          valid;
  logic          ready;
  euq_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/euq_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// euq_sqrt_cell
// One digit of a restoring integer square root, with the beat's side data.
// ----------------------------------------------------------------------------
`default_nettype none

module euq_sqrt_cell #(
  parameter int BIT_POS = 60
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  euq_pkg::pre_t          pre_i,
  input  logic [euq_pkg::NW-1:0] n_i,
  input  logic [euq_pkg::NW-1:0] r_i,
  output logic                   valid_o,
  output euq_pkg::pre_t          pre_o,
  output logic [euq_pkg::NW-1:0] n_o,
  output logic [euq_pkg::NW-1:0] r_o
);
  import euq_pkg::*;

  localparam logic [NW-1:0] BitVal = NW'(1) << BIT_POS;

  logic          valid_q;
  pre_t          pre_q;
  logic [NW-1:0] n_q, n_d, r_q, r_d;
  logic [NW:0]   sum;

  always_comb begin
    sum = {1'b0, r_i} + {1'b0, BitVal};
    if ({1'b0, n_i} >= sum) begin
      n_d = n_i - sum[NW-1:0];
      r_d = (r_i >> 1) + BitVal;
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_i;
      n_q   <= n_d;
      r_q   <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign pre_o   = pre_q;
  assign n_o     = n_q;
  assign r_o     = r_q;

endmodule

`default_nettype wire

/* hdl/euq_cordic_cell.sv */
// ----------------------------------------------------------------------------
// euq_cordic_cell
// One CORDIC micro-rotation on three lanes; rotation mode for angle beats,
// vectoring mode for quaternion beats.
// ----------------------------------------------------------------------------
`default_nettype none

module euq_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  euq_pkg::side_t        side_i,
  input  euq_pkg::lane_t [2:0]  lane_i,
  output logic                  valid_o,
  output euq_pkg::side_t        side_o,
  output euq_pkg::lane_t [2:0]  lane_o
);
  import euq_pkg::*;

  localparam logic signed [ZW-1:0] Angle = ZW'(ATAN_TAB[STEP]);

  logic          valid_q;
  side_t         side_q;
  lane_t [2:0]   lane_q, lane_d;
  logic  [2:0]   pos;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      pos[l] = side_i.kind ? (lane_i[l].y < 0) : (lane_i[l].z >= 0);
      if (pos[l]) begin
        lane_d[l].x = lane_i[l].x - (lane_i[l].y >>> STEP);
        lane_d[l].y = lane_i[l].y + (lane_i[l].x >>> STEP);
        lane_d[l].z = lane_i[l].z - Angle;
      end else begin
        lane_d[l].x = lane_i[l].x + (lane_i[l].y >>> STEP);
        lane_d[l].y = lane_i[l].y - (lane_i[l].x >>> STEP);
        lane_d[l].z = lane_i[l].z + Angle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign lane_o  = lane_q;

endmodule

`default_nettype wire

/* hdl/euler_quaternion_convert.sv */
// ----------------------------------------------------------------------------
// euler_quaternion_convert
// Roll-pitch-yaw binary angles to Q2.30 quaternion and back.
//
// in_i carries one request per beat: kind 0 converts the three angles to a
// quaternion, kind 1 converts the quaternion to roll, pitch and yaw. out_o
// returns one result beat per request, in order.
// The pipeline is three stages of products and sums, a 31-cell square-root
// chain, one setup stage, a chain of CORDIC_STEPS cells working on three
// lanes at once, and three stages of products, sums and the output register.
// Throughput is one beat per cycle while the receiver does not stall; every
// stage holds one beat.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; it rises again as soon as the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_quaternion_convert #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  euq_in_if.sink    in_i,
  euq_out_if.source out_o
);
  import euq_pkg::*;

  function automatic lane_t vec_start(input logic signed [SW-1:0] vy,
                                      input logic signed [SW-1:0] vx);
    lane_t v;
    logic signed [XW-1:0] ex, ey;
    ex = XW'(vx);
    ey = XW'(vy);
    v.z = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        v.x = ey;
        v.y = -ex;
        v.z = HALF_PI;
      end else begin
        v.x = -ey;
        v.y = ex;
        v.z = -HALF_PI;
      end
    end else begin
      v.x = ex;
      v.y = ey;
    end
    v.x = v.x <<< 16;
    v.y = v.y <<< 16;
    return v;
  endfunction

  logic en;
  logic o_valid_q;
  out_t o_q, o_d;

  assign en          = !o_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = o_valid_q;
  assign out_o.payload = o_q;

  // stage A: quaternion products
  logic               a_valid_q, a_kind_q;
  logic signed [31:0] a_roll_q, a_pitch_q, a_yaw_q;
  logic signed [QW-1:0] a_ww_q, a_xx_q, a_yy_q, a_zz_q, a_xy_q;
  logic signed [QW-1:0] a_wz_q, a_wx_q, a_yz_q, a_xz_q, a_wy_q;
  logic signed [QW-1:0] qx, qy, qz, qw;

  assign qx = QW'(in_i.payload.qx_in);
  assign qy = QW'(in_i.payload.qy_in);
  assign qz = QW'(in_i.payload.qz_in);
  assign qw = QW'(in_i.payload.qw_in);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_kind_q  <= in_i.payload.kind;
      a_roll_q  <= in_i.payload.roll_in;
      a_pitch_q <= in_i.payload.pitch_in;
      a_yaw_q   <= in_i.payload.yaw_in;
      a_ww_q    <= qmul(qw, qw);
      a_xx_q    <= qmul(qx, qx);
      a_yy_q    <= qmul(qy, qy);
      a_zz_q    <= qmul(qz, qz);
      a_xy_q    <= qmul(qx, qy);
      a_wz_q    <= qmul(qw, qz);
      a_wx_q    <= qmul(qw, qx);
      a_yz_q    <= qmul(qy, qz);
      a_xz_q    <= qmul(qx, qz);
      a_wy_q    <= qmul(qw, qy);
    end
  end

  // stage B: vector sums and sine term
  logic b_valid_q;
  pre_t b_q, b_d;

  always_comb begin
    b_d.kind   = a_kind_q;
    b_d.roll   = a_roll_q;
    b_d.pitch  = a_pitch_q;
    b_d.yaw    = a_yaw_q;
    b_d.yaw_y  = (SW'(a_xy_q) + SW'(a_wz_q)) <<< 1;
    b_d.yaw_x  = SW'(a_ww_q) + SW'(a_xx_q) - SW'(a_yy_q) - SW'(a_zz_q);
    b_d.roll_y = (SW'(a_wx_q) + SW'(a_yz_q)) <<< 1;
    b_d.roll_x = SW'(a_ww_q) - SW'(a_xx_q) - SW'(a_yy_q) + SW'(a_zz_q);
    b_d.sine   = (SW'(a_wy_q) - SW'(a_xz_q)) <<< 1;
    b_d.hi     = 1'b0;
    b_d.lo     = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en) b_q <= b_d;
  end

  // stage C: clamp detection and 1 - s*s
  logic          c_valid_q;
  pre_t          c_q, c_d;
  logic [NW-1:0] c_n_q, c_n_d;
  logic [29:0]   mag;
  logic [SW-1:0] abs_sine;

  always_comb begin
    c_d      = b_q;
    c_d.hi   = b_q.sine >= ONE_Q30;
    c_d.lo   = b_q.sine <= -ONE_Q30;
    abs_sine = b_q.sine < 0 ? -b_q.sine : b_q.sine;
    mag      = abs_sine[29:0];
    c_n_d    = (NW'(1) << 60) - NW'(mag * mag);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= c_d;
      c_n_q <= c_n_d;
    end
  end

  // square-root chain
  logic          sq_v   [SQ_CELLS+1];
  pre_t          sq_pre [SQ_CELLS+1];
  logic [NW-1:0] sq_n   [SQ_CELLS+1];
  logic [NW-1:0] sq_r   [SQ_CELLS+1];

  assign sq_v[0]   = c_valid_q;
  assign sq_pre[0] = c_q;
  assign sq_n[0]   = c_n_q;
  assign sq_r[0]   = '0;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    euq_sqrt_cell #(.BIT_POS(60 - 2 * k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .pre_i   (sq_pre[k]),
      .n_i     (sq_n[k]),
      .r_i     (sq_r[k]),
      .valid_o (sq_v[k+1]),
      .pre_o   (sq_pre[k+1]),
      .n_o     (sq_n[k+1]),
      .r_o     (sq_r[k+1])
    );
  end

  // stage P: CORDIC lane setup
  logic        p_valid_q;
  side_t       p_side_q, p_side_d;
  lane_t [2:0] p_lane_q, p_lane_d;
  pre_t        sp;
  logic signed [SW-1:0] cos_term;

  always_comb begin
    sp       = sq_pre[SQ_CELLS];
    cos_term = SW'(sq_r[SQ_CELLS]);
    p_side_d.kind = sp.kind;
    p_side_d.hi   = sp.hi;
    p_side_d.lo   = sp.lo;
    p_side_d.zero[0] = (sp.yaw_x == 0) && (sp.yaw_y == 0);
    p_side_d.zero[1] = (sp.roll_x == 0) && (sp.roll_y == 0);
    p_side_d.zero[2] = (cos_term == 0) && (sp.sine == 0);
    if (sp.kind) begin
      p_lane_d[0] = vec_start(sp.yaw_y, sp.yaw_x);
      p_lane_d[1] = vec_start(sp.roll_y, sp.roll_x);
      p_lane_d[2] = vec_start(sp.sine, cos_term);
    end else begin
      p_lane_d[0] = '{x: GAIN_INV, y: '0, z: ZW'(sp.roll >>> 1)};
      p_lane_d[1] = '{x: GAIN_INV, y: '0, z: ZW'(sp.pitch >>> 1)};
      p_lane_d[2] = '{x: GAIN_INV, y: '0, z: ZW'(sp.yaw >>> 1)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side_q <= p_side_d;
      p_lane_q <= p_lane_d;
    end
  end

  // CORDIC chain
  logic        cd_v    [CORDIC_STEPS+1];
  side_t       cd_side [CORDIC_STEPS+1];
  lane_t [2:0] cd_lane [CORDIC_STEPS+1];

  assign cd_v[0]    = p_valid_q;
  assign cd_side[0] = p_side_q;
  assign cd_lane[0] = p_lane_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    euq_cordic_cell #(.STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cd_v[i]),
      .side_i  (cd_side[i]),
      .lane_i  (cd_lane[i]),
      .valid_o (cd_v[i+1]),
      .side_o  (cd_side[i+1]),
      .lane_o  (cd_lane[i+1])
    );
  end

  // stage R: first products, angle results
  logic                 r_valid_q, r_kind_q, r_flag_q;
  logic signed [QW-1:0] r_cy_q, r_sy_q, r_cxcz_q, r_cxsz_q, r_sxcz_q, r_sxsz_q;
  logic signed [31:0]   r_roll_q, r_pitch_q, r_yaw_q;
  logic signed [31:0]   r_pitch_d;
  logic signed [ZW-1:0] pz;
  logic signed [QW-1:0] cx, sx, cz, sz;
  side_t                es;
  lane_t [2:0]          el;

  always_comb begin
    es = cd_side[CORDIC_STEPS];
    el = cd_lane[CORDIC_STEPS];
    cx = QW'(el[0].x);
    sx = QW'(el[0].y);
    cz = QW'(el[2].x);
    sz = QW'(el[2].y);
    pz = el[2].z;
    if (es.hi)                r_pitch_d = 32'sh40000000;
    else if (es.lo)           r_pitch_d = -32'sh40000000;
    else if (es.zero[2])      r_pitch_d = '0;
    else if (pz > HALF_PI)    r_pitch_d = 32'sh40000000;
    else if (pz < -HALF_PI)   r_pitch_d = -32'sh40000000;
    else                      r_pitch_d = pz[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_kind_q  <= es.kind;
      r_flag_q  <= es.hi || es.lo;
      r_yaw_q   <= es.zero[0] ? '0 : el[0].z[31:0];
      r_roll_q  <= es.zero[1] ? '0 : el[1].z[31:0];
      r_pitch_q <= r_pitch_d;
      r_cy_q    <= QW'(el[1].x);
      r_sy_q    <= QW'(el[1].y);
      r_cxcz_q  <= qmul(cx, cz);
      r_cxsz_q  <= qmul(cx, sz);
      r_sxcz_q  <= qmul(sx, cz);
      r_sxsz_q  <= qmul(sx, sz);
    end
  end

  // stage M: second products
  logic                 m_valid_q, m_kind_q, m_flag_q;
  logic signed [31:0]   m_roll_q, m_pitch_q, m_yaw_q;
  logic signed [QW-1:0] m_q [8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_kind_q  <= r_kind_q;
      m_flag_q  <= r_flag_q;
      m_roll_q  <= r_roll_q;
      m_pitch_q <= r_pitch_q;
      m_yaw_q   <= r_yaw_q;
      m_q[0]    <= qmul(r_cy_q, r_sxcz_q);
      m_q[1]    <= qmul(r_sy_q, r_cxsz_q);
      m_q[2]    <= qmul(r_cy_q, r_sxsz_q);
      m_q[3]    <= qmul(r_sy_q, r_cxcz_q);
      m_q[4]    <= qmul(r_cy_q, r_cxsz_q);
      m_q[5]    <= qmul(r_sy_q, r_sxcz_q);
      m_q[6]    <= qmul(r_cy_q, r_cxcz_q);
      m_q[7]    <= qmul(r_sy_q, r_sxsz_q);
    end
  end

  // output register
  always_comb begin
    o_d = '0;
    o_d.kind_out = m_kind_q;
    if (m_kind_q) begin
      o_d.roll_out      = m_roll_q;
      o_d.pitch_out     = m_pitch_q;
      o_d.yaw_out       = m_yaw_q;
      o_d.pitch_clamped = m_flag_q;
    end else begin
      o_d.qx_out = clamp32((QW+1)'(m_q[0]) - (QW+1)'(m_q[1]));
      o_d.qy_out = clamp32((QW+1)'(m_q[2]) + (QW+1)'(m_q[3]));
      o_d.qz_out = clamp32((QW+1)'(m_q[4]) - (QW+1)'(m_q[5]));
      o_d.qw_out = clamp32((QW+1)'(m_q[6]) + (QW+1)'(m_q[7]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) o_q <= o_d;
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      p_valid_q <= sq_v[SQ_CELLS];
      r_valid_q <= cd_v[CORDIC_STEPS];
      m_valid_q <= r_valid_q;
      o_valid_q <= m_valid_q;
    end
  end

endmodule

`default_nettype wire

/* sim/tb_euler_quaternion_convert.sv */
// ----------------------------------------------------------------------------
// tb_euler_quaternion_convert
// Streams random and corner-case angle and quaternion beats through the
// converter under bursty input and stalling output, predicts each result
// with a bit-exact CORDIC model and compares every field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euler_quaternion_convert;
  timeunit 1ns;
  timeprecision 1ps;

  import euq_pkg::*;

  localparam int STEPS   = 24;
  localparam int LATENCY = 38 + STEPS;
  localparam logic KIND_TO_QUAT  = 1'b0;
  localparam logic KIND_TO_EULER = 1'b1;
  localparam longint ONE     = 64'sd1073741824;
  localparam longint QTR_TURN = 64'sd1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  euq_in_if  req_if ();
  euq_out_if res_if ();

  euler_quaternion_convert #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (res_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  in_t    pending_q[$];
  out_t   expected_q[$];
  int     n_err = 0;
  bit     hold_off = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_phase = 0;

  longint atan_lut [40] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void rotate_cs(input longint ang, output longint c,
                                    output longint s);
    longint x, y, z, t;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < STEPS && i < 40; i++) begin
      t = x;
      if (z >= 0) begin
        x = x - (y >>> i); y = y + (t >>> i); z -= atan_lut[i];
      end else begin
        x = x + (y >>> i); y = y - (t >>> i); z += atan_lut[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_angle(longint yi, longint xi);
    longint x, y, z, t;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QTR_TURN;
      end else begin
        x = -y; y = t; z = -QTR_TURN;
      end
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < STEPS && i < 40; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i); y = y - (t >>> i); z += atan_lut[i];
      end else begin
        x = x - (y >>> i); y = y + (t >>> i); z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic out_t convert(in_t b);
    out_t   o;
    longint cx, sx, cy, sy, cz, sz, cxcz, cxsz, sxcz, sxsz;
    longint x, y, z, w, ww, xx, yy, zz, sine, pitch, c;
    longint unsigned mag;
    o = '0;
    o.kind_out = b.kind;
    if (b.kind == KIND_TO_QUAT) begin
      rotate_cs(longint'(b.roll_in) >>> 1, cx, sx);
      rotate_cs(longint'(b.pitch_in) >>> 1, cy, sy);
      rotate_cs(longint'(b.yaw_in) >>> 1, cz, sz);
      cxcz = fx_mul(cx, cz);
      cxsz = fx_mul(cx, sz);
      sxcz = fx_mul(sx, cz);
      sxsz = fx_mul(sx, sz);
      o.qx_out = 32'(sat32(fx_mul(cy, sxcz) - fx_mul(sy, cxsz)));
      o.qy_out = 32'(sat32(fx_mul(cy, sxsz) + fx_mul(sy, cxcz)));
      o.qz_out = 32'(sat32(fx_mul(cy, cxsz) - fx_mul(sy, sxcz)));
      o.qw_out = 32'(sat32(fx_mul(cy, cxcz) + fx_mul(sy, sxsz)));
    end else begin
      x = b.qx_in; y = b.qy_in; z = b.qz_in; w = b.qw_in;
      ww = fx_mul(w, w); xx = fx_mul(x, x); yy = fx_mul(y, y); zz = fx_mul(z, z);
      o.yaw_out  = 32'(vector_angle(2 * (fx_mul(x, y) + fx_mul(w, z)), ww + xx - yy - zz));
      o.roll_out = 32'(vector_angle(2 * (fx_mul(w, x) + fx_mul(y, z)), ww - xx - yy + zz));
      sine = -2 * (fx_mul(x, z) - fx_mul(w, y));
      if (sine >= ONE) begin
        pitch = QTR_TURN; o.pitch_clamped = 1'b1;
      end else if (sine <= -ONE) begin
        pitch = -QTR_TURN; o.pitch_clamped = 1'b1;
      end else begin
        mag = longint'(sine < 0 ? -sine : sine);
        c = int_sqrt((64'd1 << 60) - mag * mag);
        pitch = vector_angle(sine, c);
        if (pitch > QTR_TURN) pitch = QTR_TURN;
        if (pitch < -QTR_TURN) pitch = -QTR_TURN;
      end
      o.pitch_out = 32'(pitch);
    end
    return o;
  endfunction

  function automatic logic [31:0] rnd_edge();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h40000000;
      3: return 32'hc0000000;
      4: return 32'h00000000;
      5: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rnd_beat();
    in_t    b;
    longint q;
    b.kind = 1'($urandom_range(0, 1));
    b.roll_in = rnd_edge(); b.pitch_in = rnd_edge(); b.yaw_in = rnd_edge();
    if ($urandom_range(0, 3) != 0) begin
      // unit quaternion built from random angles
      in_t a;
      out_t r;
      a = b;
      a.kind = KIND_TO_QUAT;
      a.roll_in = $urandom; a.pitch_in = $urandom; a.yaw_in = $urandom;
      r = convert(a);
      b.qx_in = r.qx_out; b.qy_in = r.qy_out; b.qz_in = r.qz_out; b.qw_in = r.qw_out;
    end else begin
      b.qx_in = rnd_edge(); b.qy_in = rnd_edge(); b.qz_in = rnd_edge();
      q = $urandom_range(0, 1) ? longint'($signed(rnd_edge())) : 0;
      b.qw_in = 32'(q);
    end
    return b;
  endfunction

  function automatic in_t mk(logic k, logic [31:0] r, logic [31:0] p, logic [31:0] y,
                             logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                             logic [31:0] qw);
    in_t b;
    b.kind = k; b.roll_in = r; b.pitch_in = p; b.yaw_in = y;
    b.qx_in = qx; b.qy_in = qy; b.qz_in = qz; b.qw_in = qw;
    return b;
  endfunction

  initial begin
    req_if.valid = 1'b0;
    req_if.payload = '0;
    res_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    pending_q.push_back(mk(KIND_TO_QUAT, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_TO_QUAT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_TO_QUAT, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_TO_QUAT, 32'h40000000, 32'hc0000000, 32'hffffffff, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_TO_QUAT, 32'h80000000, 32'h7fffffff, 32'h00000001, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 0, 0, 0, 32'h40000000));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 0, 0, 0, 32'hc0000000));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 32'h40000000, 0, 0, 0));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 0, 32'h2d413ccd, 0, 32'h2d413ccd));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 0, 32'hd2bec333, 0, 32'h2d413ccd));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 0, 32'h2d413cc0, 0, 32'h2d413cc0));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 32'h80000000, 32'h80000000,
                           32'h80000000, 32'h80000000));
    pending_q.push_back(mk(KIND_TO_EULER, 0, 0, 0, 32'h80000000, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff));
    pending_q.push_back(mk(KIND_TO_EULER, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                           0, 0, 32'h40000000, 32'hc0000000));
    for (int i = 0; i < 900; i++) pending_q.push_back(rnd_beat());
    wait (pending_q.size() == 0);
    hold_off = 1'b1;
    wait (expected_q.size() == 0);
    hold_off = 1'b0;
    for (int i = 0; i < 930; i++) pending_q.push_back(rnd_beat());
    wait (pending_q.size() == 0 && !req_if.valid);
    wait (expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("tb_euler_quaternion_convert: clean");
    end else begin
      $display("tb_euler_quaternion_convert: errors");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("tb_euler_quaternion_convert: errors");
    $finish;
  end

  // driver: bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_q.push_back(convert(req_if.payload));
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (pending_q.size() != 0 && !hold_off) begin
          req_if.valid <= 1'b1;
          req_if.payload <= pending_q.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat, stall on a cycling pattern
  always @(posedge clk_i) begin
    out_t exp_b, got;
    if (rst_ni) begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) res_if.ready <= 1'b1;
      else if (stall_phase < 200) res_if.ready <= ($urandom_range(0, 3) != 0);
      else res_if.ready <= ($urandom_range(0, 1) == 0);
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        if (expected_q.size() == 0) begin
          $display("%t unexpected beat: actual %h", $realtime, got);
          n_err++;
        end else begin
          exp_b = expected_q.pop_front();
          if (got !== exp_b) begin
            $display("%t mismatch: expected %h actual %h", $realtime, exp_b, got);
            n_err++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* euler_quaternion_convert.f */
hdl/euq_pkg.sv
hdl/euq_if.sv
hdl/euq_sqrt_cell.sv
hdl/euq_cordic_cell.sv
hdl/euler_quaternion_convert.sv
sim/tb_euler_quaternion_convert.sv
